[src/chm_pkg.sv]
// shared types, constants and helpers for the chained hash map
`timescale 1ns / 1ps

package chm_pkg;

  localparam int SUM_W       = 32;
  localparam int VAL_W       = 31;
  localparam int TAG_W       = 4;
  localparam int REM_W       = 11;
  localparam int STEP_BITS   = 4;
  localparam int MOD_A_STEPS = SUM_W / STEP_BITS;
  localparam int MOD_B_STEPS = 3;
  localparam int CNT_W       = 3;

  localparam logic [REM_W-1:0] TAG_PRIME  = 11'd751;
  localparam logic [REM_W-1:0] TAG_MOD    = 11'd15;
  localparam logic [SUM_W-1:0] DIGIT_ZERO = 32'd48;

  localparam int DEF_PRIMARY_SLOTS = 30;
  localparam int DEF_POOL_NODES    = 15;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RES_DONE,
    RES_FULL,
    RES_SLOT,
    RES_POOL,
    RES_MISS
  } res_sel_t;

  typedef struct packed {
    logic     byte_acc;
    logic     mod_both;
    logic     mod_tag15;
    logic     load_b;
    logic     slot_rd;
    logic     slot_fill;
    logic     slot_link;
    logic     pool_alloc;
    logic     pool_rd_slot;
    logic     pool_rd_next;
    logic     pool_link_wr;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic act;
    logic slot_empty;
    logic slot_link_ok;
    logic slot_tag_hit;
    logic pool_full;
    logic pool_link_ok;
    logic pool_tag_hit;
  } stat_t;

  // one restoring step of a remainder by a constant modulus
  function automatic logic [REM_W-1:0] mod_step(logic [REM_W-1:0] r, logic b,
                                                logic [REM_W-1:0] m);
    logic [REM_W-1:0] t;
    t = {r[REM_W-2:0], b};
    if (t >= m) begin
      t = t - m;
    end
    return t;
  endfunction

endpackage

[src/chm_ctrl.sv]
// controller state machine of the chained hash map
`timescale 1ns / 1ps

module chm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          name_last,
  output logic          out_valid,
  input  logic          out_stall,
  input  chm_pkg::stat_t stat,
  output chm_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MODA,
    S_LOADB,
    S_MODB,
    S_EVAL,
    S_APPEND,
    S_LOOKUP,
    S_DONE
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [chm_pkg::CNT_W-1:0] cnt;
  logic [chm_pkg::CNT_W-1:0] cnt_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.byte_acc = 1'b1;
          if (name_last) begin
            state_next = S_MODA;
            cnt_next   = '0;
          end
        end
      end
      S_MODA: begin
        cmd.mod_both = 1'b1;
        if (cnt == chm_pkg::CNT_W'(chm_pkg::MOD_A_STEPS - 1)) begin
          state_next = S_LOADB;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_LOADB: begin
        cmd.load_b  = 1'b1;
        cmd.slot_rd = 1'b1;
        state_next  = S_MODB;
      end
      S_MODB: begin
        cmd.mod_tag15 = 1'b1;
        if (cnt == chm_pkg::CNT_W'(chm_pkg::MOD_B_STEPS - 1)) begin
          state_next = S_EVAL;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EVAL: begin
        if (!stat.act) begin
          if (stat.slot_empty) begin
            cmd.slot_fill = 1'b1;
            cmd.res_load  = 1'b1;
            cmd.res_sel   = chm_pkg::RES_DONE;
            state_next    = S_DONE;
          end else if (stat.pool_full) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = chm_pkg::RES_FULL;
            state_next   = S_DONE;
          end else begin
            cmd.pool_alloc = 1'b1;
            if (!stat.slot_link_ok) begin
              cmd.slot_link = 1'b1;
              cmd.res_load  = 1'b1;
              cmd.res_sel   = chm_pkg::RES_DONE;
              state_next    = S_DONE;
            end else begin
              cmd.pool_rd_slot = 1'b1;
              state_next       = S_APPEND;
            end
          end
        end else begin
          if (!stat.slot_link_ok || stat.slot_tag_hit) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = chm_pkg::RES_SLOT;
            state_next   = S_DONE;
          end else begin
            cmd.pool_rd_slot = 1'b1;
            state_next       = S_LOOKUP;
          end
        end
      end
      S_APPEND: begin
        // walk to the chain tail, then hook the new node on
        if (stat.pool_link_ok) begin
          cmd.pool_rd_next = 1'b1;
        end else begin
          cmd.pool_link_wr = 1'b1;
          cmd.res_load     = 1'b1;
          cmd.res_sel      = chm_pkg::RES_DONE;
          state_next       = S_DONE;
        end
      end
      S_LOOKUP: begin
        if (stat.pool_tag_hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = chm_pkg::RES_POOL;
          state_next   = S_DONE;
        end else if (stat.pool_link_ok) begin
          cmd.pool_rd_next = 1'b1;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = chm_pkg::RES_MISS;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[src/chm_datapath.sv]
// datapath: name sums, modulo reduction, slot and pool stores, result register
`timescale 1ns / 1ps

module chm_datapath #(
  parameter int PRIMARY_SLOTS = chm_pkg::DEF_PRIMARY_SLOTS,
  parameter int POOL_NODES    = chm_pkg::DEF_POOL_NODES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  chm_pkg::cmd_t               cmd,
  output chm_pkg::stat_t              stat,
  input  logic                        action,
  input  logic [7:0]                  name_byte,
  input  logic                        name_last,
  input  logic [chm_pkg::VAL_W-1:0]   fd_value,
  output logic signed [31:0]          found_value,
  output logic [1:0]                  status
);

  localparam int SW = $clog2(PRIMARY_SLOTS);
  localparam int LW = $clog2(POOL_NODES + 1);
  localparam int PW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int SUM_W = chm_pkg::SUM_W;
  localparam int VAL_W = chm_pkg::VAL_W;
  localparam int TAG_W = chm_pkg::TAG_W;
  localparam int REM_W = chm_pkg::REM_W;
  localparam logic [LW-1:0]    NULL_LINK = LW'(POOL_NODES);
  localparam logic [REM_W-1:0] SLOT_M    = REM_W'(PRIMARY_SLOTS);

  // name sums and reduction
  logic [SUM_W-1:0] slot_sum;
  logic [SUM_W-1:0] tag_sum;
  logic [SUM_W-1:0] sh_slot;
  logic [SUM_W-1:0] sh_tag;
  logic [REM_W-1:0] r_slot;
  logic [REM_W-1:0] r_tag;
  logic             act;
  logic [VAL_W-1:0] val;

  logic [SUM_W-1:0] d;
  logic [SUM_W-1:0] slot_sum_next;
  logic [SUM_W-1:0] tag_sum_next;
  logic [REM_W-1:0] r_slot_next;
  logic [REM_W-1:0] r_tag_next;
  logic [REM_W-1:0] tag_m;

  // slot store, cleared by valid bits
  logic [VAL_W-1:0]         slot_val_mem  [PRIMARY_SLOTS];
  logic [TAG_W-1:0]         slot_tag_mem  [PRIMARY_SLOTS];
  logic [LW-1:0]            slot_link_mem [PRIMARY_SLOTS];
  logic [PRIMARY_SLOTS-1:0] slot_valid;
  logic [VAL_W-1:0]         slot_q_val;
  logic [TAG_W-1:0]         slot_q_tag;
  logic [LW-1:0]            slot_q_link;
  logic                     slot_q_vld;
  logic [VAL_W-1:0]         slot_eff_val;
  logic [TAG_W-1:0]         slot_eff_tag;
  logic [LW-1:0]            slot_eff_link;
  logic [SW-1:0]            slot_idx;
  logic [TAG_W-1:0]         tag;
  logic [LW-1:0]            slot_link_wdata;

  // chain pool, filled in order so the fill count covers reset
  logic [VAL_W-1:0] pool_val_mem  [POOL_NODES];
  logic [TAG_W-1:0] pool_tag_mem  [POOL_NODES];
  logic [LW-1:0]    pool_link_mem [POOL_NODES];
  logic [LW-1:0]    pool_used;
  logic [LW-1:0]    new_node;
  logic [LW-1:0]    cur;
  logic [LW-1:0]    pool_raddr;
  logic [PW-1:0]    pool_lwaddr;
  logic [LW-1:0]    pool_lwdata;
  logic [VAL_W-1:0] pool_q_val;
  logic [TAG_W-1:0] pool_q_tag;
  logic [LW-1:0]    pool_q_link;

  logic [31:0] res_found;
  logic [1:0]  res_status;

  assign d             = {{(SUM_W-8){name_byte[7]}}, name_byte} - chm_pkg::DIGIT_ZERO;
  assign slot_sum_next = slot_sum + d;
  assign tag_sum_next  = tag_sum + ~(d << 1);
  assign tag_m         = cmd.mod_tag15 ? chm_pkg::TAG_MOD : chm_pkg::TAG_PRIME;

  always_comb begin
    r_slot_next = r_slot;
    r_tag_next  = r_tag;
    for (int i = 0; i < chm_pkg::STEP_BITS; i++) begin
      r_slot_next = chm_pkg::mod_step(r_slot_next, sh_slot[SUM_W-1-i], SLOT_M);
      r_tag_next  = chm_pkg::mod_step(r_tag_next, sh_tag[SUM_W-1-i], tag_m);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_sum <= '0;
      tag_sum  <= '0;
    end else if (cmd.byte_acc) begin
      if (name_last) begin
        slot_sum <= '0;
        tag_sum  <= '0;
      end else begin
        slot_sum <= slot_sum_next;
        tag_sum  <= tag_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_acc && name_last) begin
      sh_slot <= slot_sum_next;
      sh_tag  <= tag_sum_next;
      r_slot  <= '0;
      r_tag   <= '0;
      act     <= action;
      val     <= fd_value;
    end else if (cmd.mod_both) begin
      sh_slot <= sh_slot << chm_pkg::STEP_BITS;
      sh_tag  <= sh_tag << chm_pkg::STEP_BITS;
      r_slot  <= r_slot_next;
      r_tag   <= r_tag_next;
    end else if (cmd.load_b) begin
      // second pass: remainder by the prime, now by the tag modulus
      sh_tag <= {1'b0, r_tag, {(SUM_W-REM_W-1){1'b0}}};
      r_tag  <= '0;
    end else if (cmd.mod_tag15) begin
      sh_tag <= sh_tag << chm_pkg::STEP_BITS;
      r_tag  <= r_tag_next;
    end
  end

  assign slot_idx = r_slot[SW-1:0];
  assign tag      = r_tag[TAG_W-1:0];

  assign slot_eff_val  = slot_q_vld ? slot_q_val  : '0;
  assign slot_eff_tag  = slot_q_vld ? slot_q_tag  : '0;
  assign slot_eff_link = slot_q_vld ? slot_q_link : NULL_LINK;
  assign slot_link_wdata = cmd.slot_fill ? slot_eff_link : pool_used;

  always_ff @(posedge clk) begin
    if (cmd.slot_rd) begin
      slot_q_val  <= slot_val_mem[slot_idx];
      slot_q_tag  <= slot_tag_mem[slot_idx];
      slot_q_link <= slot_link_mem[slot_idx];
    end
    if (cmd.slot_fill) begin
      slot_val_mem[slot_idx] <= val;
      slot_tag_mem[slot_idx] <= tag;
    end
    if (cmd.slot_fill || cmd.slot_link) begin
      slot_link_mem[slot_idx] <= slot_link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_q_vld <= 1'b0;
    end else begin
      if (cmd.slot_rd) begin
        slot_q_vld <= slot_valid[slot_idx];
      end
      if (cmd.slot_fill || cmd.slot_link) begin
        slot_valid[slot_idx] <= 1'b1;
      end
    end
  end

  assign pool_raddr  = cmd.pool_rd_slot ? slot_eff_link : pool_q_link;
  assign pool_lwaddr = cmd.pool_alloc ? pool_used[PW-1:0] : cur[PW-1:0];
  assign pool_lwdata = cmd.pool_alloc ? NULL_LINK : new_node;

  always_ff @(posedge clk) begin
    if (cmd.pool_rd_slot || cmd.pool_rd_next) begin
      pool_q_val  <= pool_val_mem[pool_raddr[PW-1:0]];
      pool_q_tag  <= pool_tag_mem[pool_raddr[PW-1:0]];
      pool_q_link <= pool_link_mem[pool_raddr[PW-1:0]];
      cur         <= pool_raddr;
    end
    if (cmd.pool_alloc) begin
      pool_val_mem[pool_used[PW-1:0]] <= val;
      pool_tag_mem[pool_used[PW-1:0]] <= tag;
      new_node                        <= pool_used;
    end
    if (cmd.pool_alloc || cmd.pool_link_wr) begin
      pool_link_mem[pool_lwaddr] <= pool_lwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_used <= '0;
    end else if (cmd.pool_alloc) begin
      pool_used <= pool_used + 1'b1;
    end
  end

  assign stat.act          = act;
  assign stat.slot_empty   = (slot_eff_val == '0);
  assign stat.slot_link_ok = (slot_eff_link < NULL_LINK);
  assign stat.slot_tag_hit = (slot_eff_tag == tag);
  assign stat.pool_full    = (pool_used >= NULL_LINK);
  assign stat.pool_link_ok = (pool_q_link < NULL_LINK);
  assign stat.pool_tag_hit = (pool_q_tag == tag);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        chm_pkg::RES_DONE: begin
          res_found  <= '0;
          res_status <= chm_pkg::ST_DONE;
        end
        chm_pkg::RES_FULL: begin
          res_found  <= '0;
          res_status <= chm_pkg::ST_FULL;
        end
        chm_pkg::RES_SLOT: begin
          res_found  <= {1'b0, slot_eff_val};
          res_status <= chm_pkg::ST_DONE;
        end
        chm_pkg::RES_POOL: begin
          res_found  <= {1'b0, pool_q_val};
          res_status <= chm_pkg::ST_DONE;
        end
        chm_pkg::RES_MISS: begin
          res_found  <= '1;
          res_status <= chm_pkg::ST_MISS;
        end
        default: begin
          res_found  <= '1;
          res_status <= chm_pkg::ST_MISS;
        end
      endcase
    end
    if (cmd.out_load) begin
      found_value <= res_found;
      status      <= res_status;
    end
  end

endmodule

[src/chained_hash_map_name_to_value.sv]
// top level of the chained hash map from names to values
`timescale 1ns / 1ps

// A name enters one byte per cycle with name_last on its final byte, and
// the action and fd_value of that final byte decide the transaction. Bytes
// before the last are taken every cycle and give no result. After the last
// byte the input stalls while the two 32-bit name sums are reduced four bits
// a cycle: first the slot and prime remainders, then a step that starts the
// tag pass and reads the slot, then the tag remainder. The slot is then
// evaluated, each chain node walked goes through the pool read port, and the
// result moves to the output register once no earlier result is held there
// under out_stall. Stores are empty right after reset with no clearing pass.
module chained_hash_map_name_to_value #(
  parameter int PRIMARY_SLOTS = chm_pkg::DEF_PRIMARY_SLOTS,
  parameter int POOL_NODES    = chm_pkg::DEF_POOL_NODES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [7:0]                name_byte,
  input  logic                      name_last,
  input  logic [chm_pkg::VAL_W-1:0] fd_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        found_value,
  output logic [1:0]                status
);

  chm_pkg::cmd_t  cmd;
  chm_pkg::stat_t stat;

  chm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .name_last (name_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  chm_datapath #(
    .PRIMARY_SLOTS (PRIMARY_SLOTS),
    .POOL_NODES    (POOL_NODES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (action),
    .name_byte   (name_byte),
    .name_last   (name_last),
    .fd_value    (fd_value),
    .found_value (found_value),
    .status      (status)
  );

endmodule

[src/chm_checker.sv]
// port-level checks for the chained hash map, bound to the top level
`timescale 1ns / 1ps

module chm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               name_last,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] found_value,
  input logic [1:0]         status
);

  // no result may be pending right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // a final byte starts the slot work, so the input stalls next cycle
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && name_last |=> in_stall)
    else $error("input not stalled after final byte");

  // a miss always reports minus one
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == chm_pkg::ST_MISS |-> found_value == '1)
    else $error("miss without minus one");

  // a dropped insert reports zero
  a_full_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == chm_pkg::ST_FULL |-> found_value == '0)
    else $error("pool full transaction with nonzero value");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found_value) && $stable(status))
    else $error("stalled result changed");

endmodule

bind chained_hash_map_name_to_value chm_checker u_chm_checker (.*);

[tb/tb.sv]
// self-checking testbench for the chained hash map from names to values
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS        = chm_pkg::DEF_PRIMARY_SLOTS;
  localparam int NODES        = chm_pkg::DEF_POOL_NODES;
  localparam int NULL_LINK    = NODES;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_BYTES  = 125;
  localparam int NAME_SLOTS   = 64;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct {
    logic [31:0]      found;
    chm_pkg::status_t st;
  } answer_t;

  // keeps its own copy of the map and the queue of answers still owed
  class hash_map_board;
    logic [31:0]               name_slot_sum;
    logic [31:0]               name_tag_sum;
    logic [chm_pkg::VAL_W-1:0] head_value [SLOTS];
    logic [chm_pkg::TAG_W-1:0] head_tag   [SLOTS];
    int                        head_link  [SLOTS];
    logic [chm_pkg::VAL_W-1:0] node_value [NODES];
    logic [chm_pkg::TAG_W-1:0] node_tag   [NODES];
    int                        node_link  [NODES];
    int                        nodes_taken;
    answer_t                   answers[$];
    int                        errors, checked, inserts, lookups, drops, misses, hits;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        head_value[i] = '0;
        head_tag[i]   = '0;
        head_link[i]  = NULL_LINK;
      end
      for (int i = 0; i < NODES; i++) begin
        node_value[i] = '0;
        node_tag[i]   = '0;
        node_link[i]  = NULL_LINK;
      end
      nodes_taken   = 0;
      name_slot_sum = '0;
      name_tag_sum  = '0;
      errors  = 0;
      checked = 0;
      inserts = 0;
      lookups = 0;
      drops   = 0;
      misses  = 0;
      hits    = 0;
    endfunction

    function chm_pkg::status_t store(int slot, logic [chm_pkg::TAG_W-1:0] tag,
                                     logic [chm_pkg::VAL_W-1:0] val);
      int node;
      int cur;
      if (head_value[slot] == '0) begin
        head_value[slot] = val;
        head_tag[slot]   = tag;
        return chm_pkg::ST_DONE;
      end
      if (nodes_taken >= NODES) return chm_pkg::ST_FULL;
      node = nodes_taken;
      nodes_taken++;
      node_value[node] = val;
      node_tag[node]   = tag;
      node_link[node]  = NULL_LINK;
      if (head_link[slot] >= NODES) begin
        head_link[slot] = node;
        return chm_pkg::ST_DONE;
      end
      cur = head_link[slot];
      for (int s = 0; s < NODES; s++) begin
        if (node_link[cur] >= NODES) break;
        cur = node_link[cur];
      end
      node_link[cur] = node;
      return chm_pkg::ST_DONE;
    endfunction

    function answer_t search(int slot, logic [chm_pkg::TAG_W-1:0] tag);
      answer_t a;
      int cur;
      a.found = {1'b0, head_value[slot]};
      a.st    = chm_pkg::ST_DONE;
      // a slot without a chain answers with its own value whatever the tag
      if (head_link[slot] >= NODES || head_tag[slot] == tag) return a;
      cur = head_link[slot];
      for (int s = 0; s < NODES && cur < NODES; s++) begin
        if (node_tag[cur] == tag) begin
          a.found = {1'b0, node_value[cur]};
          return a;
        end
        cur = node_link[cur];
      end
      a.found = '1;
      a.st    = chm_pkg::ST_MISS;
      return a;
    endfunction

    function void note_byte(logic act, logic [7:0] nb, logic last,
                            logic [chm_pkg::VAL_W-1:0] val);
      logic [31:0]               d;
      int                        slot;
      logic [chm_pkg::TAG_W-1:0] tag;
      answer_t                   a;
      d = {{24{nb[7]}}, nb} - chm_pkg::DIGIT_ZERO;
      name_slot_sum += d;
      name_tag_sum  += ~(d << 1);
      if (!last) return;
      slot = int'(name_slot_sum % $unsigned(SLOTS));
      tag  = chm_pkg::TAG_W'((name_tag_sum % chm_pkg::TAG_PRIME) % chm_pkg::TAG_MOD);
      name_slot_sum = '0;
      name_tag_sum  = '0;
      if (act == ACT_INSERT) begin
        a.found = '0;
        a.st    = store(slot, tag, val);
        inserts++;
        if (a.st == chm_pkg::ST_FULL) drops++;
      end else begin
        a = search(slot, tag);
        lookups++;
        if (a.st == chm_pkg::ST_MISS) misses++;
        else if (a.found != '0) hits++;
      end
      answers.push_back(a);
    endfunction

    function void check_result(logic [31:0] fv, logic [1:0] st);
      answer_t a;
      if (answers.size() == 0) begin
        $display("%0t: result with nothing expected, found_value %h status %0d",
                 $time, fv, st);
        errors++;
        return;
      end
      a = answers.pop_front();
      checked++;
      if (fv !== a.found) begin
        $display("%0t: found_value expected %h actual %h", $time, a.found, fv);
        errors++;
      end
      if (st !== a.st) begin
        $display("%0t: status expected %0d actual %0d", $time, a.st, st);
        errors++;
      end
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic                      action    = ACT_INSERT;
  logic [7:0]                name_byte = '0;
  logic                      name_last = 1'b0;
  logic [chm_pkg::VAL_W-1:0] fd_value  = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [31:0]        found_value;
  logic [1:0]                status;

  hash_map_board board;
  int               cycles     = 0;
  int               idle_pct   = 0;
  int               stall_pct  = 0;
  int               bytes_sent = 0;
  logic [63:0]      known_name [NAME_SLOTS];
  int               known_len  [NAME_SLOTS];
  int               known_count = 0;

  chained_hash_map_name_to_value dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .name_byte  (name_byte),
    .name_last  (name_last),
    .fd_value   (fd_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found_value(found_value),
    .status     (status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, board.answers.size());
      $display("chained_hash_map_name_to_value verification failed");
      $finish;
    end else if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      board.check_result(found_value, status);
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_byte(logic act, logic [7:0] nb, logic last,
                           logic [chm_pkg::VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    name_byte <= nb;
    name_last <= last;
    fd_value  <= val;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_byte(act, nb, last, val);
    bytes_sent++;
    @(negedge clk);
  endtask

  // only the last byte's action and value matter, the others get noise
  task automatic send_name(logic act, logic [63:0] nm, int len,
                           logic [chm_pkg::VAL_W-1:0] val);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) send_byte(act, nm[8*i +: 8], 1'b1, val);
      else send_byte(1'($urandom_range(1)), nm[8*i +: 8], 1'b0,
                     chm_pkg::VAL_W'($urandom));
    end
  endtask

  function automatic logic [63:0] random_name(int len);
    logic [63:0] nm;
    nm = '0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 60) nm[8*i +: 8] = 8'(48 + $urandom_range(42));
      else nm[8*i +: 8] = 8'($urandom);
    end
    return nm;
  endfunction

  function automatic logic [chm_pkg::VAL_W-1:0] random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 15) return '1;
    return chm_pkg::VAL_W'($urandom);
  endfunction

  // mostly look-ups of stored names and repeated inserts, some fresh names
  task automatic random_traffic(int budget);
    int          stop;
    int          len;
    int          idx;
    logic [63:0] nm;
    logic        act;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      act = 1'($urandom_range(1));
      if (act == ACT_LOOKUP && known_count > 0 && $urandom_range(99) < 80) begin
        idx = $urandom_range(known_count - 1);
        send_name(ACT_LOOKUP, known_name[idx], known_len[idx], random_value());
      end else if (act == ACT_INSERT && known_count > 0 && $urandom_range(99) < 40) begin
        idx = $urandom_range(known_count - 1);
        send_name(ACT_INSERT, known_name[idx], known_len[idx], random_value());
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(8, 1) : $urandom_range(3, 1);
        nm  = random_name(len);
        if (act == ACT_INSERT) begin
          idx = (known_count < NAME_SLOTS) ? known_count : $urandom_range(NAME_SLOTS - 1);
          known_name[idx] = nm;
          known_len[idx]  = len;
          if (known_count < NAME_SLOTS) known_count++;
        end
        send_name(act, nm, len, random_value());
      end
    end
  endtask

  initial begin
    int idle_set  [4];
    int stall_set [4];
    idle_set  = '{0, 79, 0, 38};
    stall_set = '{0, 0, 79, 38};
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_name(ACT_LOOKUP, 64'h30, 1, '0);        // look-up of an empty slot
    send_name(ACT_INSERT, 64'h00, 1, '0);        // zero value keeps the slot empty
    send_name(ACT_LOOKUP, 64'h00, 1, '1);
    send_name(ACT_INSERT, 64'h00, 1, '1);
    send_name(ACT_LOOKUP, 64'h00, 1, '0);
    send_name(ACT_INSERT, 64'hFF, 1, 31'd1);
    send_name(ACT_INSERT, 64'h80, 1, 31'd2);
    send_name(ACT_INSERT, 64'h7F, 1, 31'd3);
    send_name(ACT_INSERT, 64'h333231, 3, 31'd5);
    send_name(ACT_INSERT, 64'h333231, 3, 31'd6); // duplicate name goes to the chain
    send_name(ACT_LOOKUP, 64'h333231, 3, '0);
    send_name(ACT_LOOKUP, 64'hFF, 1, '0);
    // same slot sum, different length gives a different tag
    send_name(ACT_INSERT, 64'h30, 1, 31'd7);
    send_name(ACT_INSERT, 64'h3030, 2, 31'd8);
    send_name(ACT_LOOKUP, 64'h3030, 2, '0);
    send_name(ACT_LOOKUP, 64'h303030, 3, '0);    // chained slot, no tag match

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      random_traffic(PHASE_BYTES);
    end
    in_valid <= 1'b0;

    while (board.answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d names in %0d bytes: %0d inserts, %0d dropped on a full pool",
             board.inserts + board.lookups, bytes_sent, board.inserts, board.drops);
    $display("%0d look-ups, %0d hit a stored value, %0d missed; %0d results checked",
             board.lookups, board.hits, board.misses, board.checked);
    if (board.errors == 0) begin
      $display("chained_hash_map_name_to_value verification clean");
    end else begin
      $display("chained_hash_map_name_to_value verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/chm_pkg.sv
src/chm_ctrl.sv
src/chm_datapath.sv
src/chained_hash_map_name_to_value.sv
src/chm_checker.sv
tb/tb.sv
